// ----- sv/ptl_pkg.sv -----
`timescale 1ns / 1ps

package ptl_pkg;

    localparam int MAX_TOKEN_LEN = 255;
    localparam int LEN_CAP_INT   = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
    localparam logic [7:0] LEN_CAP = 8'(LEN_CAP_INT);

    localparam int NKW = 15;
    localparam logic [NKW-1:0] ALL_KW = '1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int DATA_IN_W  = 8;
    localparam int DATA_OUT_W = 40;
    localparam int USER_W     = 6;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    typedef enum logic [5:0] {
        K_EOF      = 6'd0,
        K_NEWLINE  = 6'd1,
        K_LINEWRAP = 6'd2,
        K_IDENT    = 6'd3,
        K_INT      = 6'd4,
        K_DEFINE   = 6'd5,
        K_UNDEF    = 6'd6,
        K_IFDEF    = 6'd7,
        K_IFNDEF   = 6'd8,
        K_IF       = 6'd9,
        K_ELIF     = 6'd10,
        K_ELSE     = 6'd11,
        K_ENDIF    = 6'd12,
        K_ERROR    = 6'd13,
        K_PRAGMA   = 6'd14,
        K_EXT      = 6'd15,
        K_VERSION  = 6'd16,
        K_LINE     = 6'd17,
        K_INCLUDE  = 6'd18,
        K_DEFINED  = 6'd19,
        K_LPAREN   = 6'd20,
        K_RPAREN   = 6'd21,
        K_COMMA    = 6'd22,
        K_COLON    = 6'd23,
        K_PLUS     = 6'd24,
        K_MINUS    = 6'd25,
        K_TIMES    = 6'd26,
        K_DIVIDE   = 6'd27,
        K_MOD      = 6'd28,
        K_EQ       = 6'd29,
        K_NE       = 6'd30,
        K_LT       = 6'd31,
        K_LE       = 6'd32,
        K_GT       = 6'd33,
        K_GE       = 6'd34,
        K_BAND     = 6'd35,
        K_BOR      = 6'd36,
        K_BNOT     = 6'd37,
        K_BXOR     = 6'd38,
        K_LAND     = 6'd39,
        K_LOR      = 6'd40,
        K_LNOT     = 6'd41,
        K_ERR      = 6'd42
    } t_kind;

    typedef enum logic [3:0] {
        M_IDLE      = 4'd0,
        M_IDENT     = 4'd1,
        M_NUMBER    = 4'd2,
        M_HASH      = 4'd3,
        M_BSLASH    = 4'd4,
        M_BSLASH_CR = 4'd5,
        M_EQ        = 4'd6,
        M_BANG      = 4'd7,
        M_LT        = 4'd8,
        M_GT        = 4'd9,
        M_AMP       = 4'd10,
        M_PIPE      = 4'd11
    } t_mode;

    typedef struct packed {
        logic [7:0]  len;
        logic [31:0] start;
        t_kind       kind;
    } t_tok;

    // tokens caused by one source byte
    typedef struct packed {
        logic two;
        t_tok tok1;
        t_tok tok0;
    } t_rec;

    // keyword text, right-justified
    localparam logic [127:0] KW_TEXT [NKW] = '{
        128'("#define"), 128'("#undef"), 128'("#ifdef"), 128'("#ifndef"),
        128'("#if"), 128'("#elif"), 128'("#else"), 128'("#endif"),
        128'("#error"), 128'("#pragma"), 128'("#extension"), 128'("#version"),
        128'("#line"), 128'("#include"), 128'("defined")
    };

    localparam logic [3:0] KW_LEN [NKW] = '{
        4'd7, 4'd6, 4'd6, 4'd7, 4'd3, 4'd5, 4'd5, 4'd6,
        4'd6, 4'd7, 4'd10, 4'd8, 4'd5, 4'd8, 4'd7
    };

    function automatic logic [NKW-1:0] kw_filter(input logic [NKW-1:0] cand,
                                                 input logic [7:0] len,
                                                 input logic [7:0] c);
        logic [NKW-1:0] r;
        logic [3:0]     sh;
        r  = cand;
        sh = '0;
        for (int k = 0; k < NKW; k++) begin
            if (len >= {4'd0, KW_LEN[k]}) begin
                r[k] = 1'b0;
            end else begin
                sh = KW_LEN[k] - 4'd1 - len[3:0];
                if (KW_TEXT[k][{sh, 3'b000} +: 8] != c) begin
                    r[k] = 1'b0;
                end
            end
        end
        return r;
    endfunction

    function automatic t_kind kw_kind(input logic [NKW-1:0] cand, input logic [7:0] len);
        t_kind r;
        r = K_IDENT;
        for (int k = 0; k < NKW; k++) begin
            if (cand[k] && (len == {4'd0, KW_LEN[k]})) begin
                r = t_kind'(6'(int'(K_DEFINE) + k));
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] len_bump(input logic [7:0] len);
        return (len < LEN_CAP) ? len + 8'd1 : len;
    endfunction

endpackage

// ----- sv/ptl_front.sv -----
`timescale 1ns / 1ps

module ptl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_acc,
    input  logic [7:0]    i_char,
    output logic          o_push,
    output ptl_pkg::t_rec o_rec
);
    import ptl_pkg::*;

    t_mode          r_mode, n_mode;
    logic [NKW-1:0] r_cand, n_cand;
    logic [7:0]     r_len, n_len;
    logic [31:0]    r_start, n_start;
    logic [31:0]    r_pos;

    logic used;
    logic pend_v, idl_v;
    t_tok pend, idl;

    logic is_letter, is_digit, is_ident;

    assign is_letter = ((i_char >= "a") && (i_char <= "z")) ||
                       ((i_char >= "A") && (i_char <= "Z"));
    assign is_digit  = (i_char >= "0") && (i_char <= "9");
    assign is_ident  = is_letter || is_digit || (i_char == "_");

    always_comb begin
        n_mode  = r_mode;
        n_cand  = r_cand;
        n_len   = r_len;
        n_start = r_start;
        used    = 1'b0;
        pend_v  = 1'b0;
        pend    = '{len: 8'd0, start: r_start, kind: K_ERR};
        idl_v   = 1'b0;
        idl     = '{len: 8'd0, start: r_pos, kind: K_ERR};

        // held token sees the byte first
        unique case (r_mode)
            M_IDENT: begin
                if (is_ident) begin
                    n_cand = kw_filter(r_cand, r_len, i_char);
                    n_len  = len_bump(r_len);
                    used   = 1'b1;
                end else begin
                    pend_v    = 1'b1;
                    pend.kind = kw_kind(r_cand, r_len);
                    pend.len  = r_len;
                end
            end
            M_NUMBER: begin
                if (is_digit) begin
                    n_len = len_bump(r_len);
                    n_cand = kw_filter(r_cand, r_len, i_char);
                    used  = 1'b1;
                end else begin
                    pend_v    = 1'b1;
                    pend.kind = K_INT;
                    pend.len  = r_len;
                end
            end
            M_HASH: begin
                if ((i_char == " ") || (i_char == CH_TAB)) begin
                    used = 1'b1;
                end else if (is_letter) begin
                    n_mode = M_IDENT;
                    n_cand = kw_filter(r_cand, r_len, i_char);
                    n_len  = len_bump(r_len);
                    used   = 1'b1;
                end else begin
                    pend_v    = 1'b1;
                    pend.kind = K_ERR;
                    pend.len  = r_len;
                end
            end
            M_BSLASH: begin
                if (i_char == CH_CR) begin
                    n_mode = M_BSLASH_CR;
                    used   = 1'b1;
                end else begin
                    pend_v    = 1'b1;
                    used      = (i_char == CH_LF);
                    pend.kind = used ? K_LINEWRAP : K_ERR;
                end
            end
            M_BSLASH_CR: begin
                pend_v    = 1'b1;
                used      = (i_char == CH_LF);
                pend.kind = used ? K_LINEWRAP : K_ERR;
            end
            M_EQ: begin
                pend_v    = 1'b1;
                used      = (i_char == "=");
                pend.kind = used ? K_EQ : K_ERR;
            end
            M_BANG: begin
                pend_v    = 1'b1;
                used      = (i_char == "=");
                pend.kind = used ? K_NE : K_LNOT;
            end
            M_LT: begin
                pend_v    = 1'b1;
                used      = (i_char == "=");
                pend.kind = used ? K_LE : K_LT;
            end
            M_GT: begin
                pend_v    = 1'b1;
                used      = (i_char == "=");
                pend.kind = used ? K_GE : K_GT;
            end
            M_AMP: begin
                pend_v    = 1'b1;
                used      = (i_char == "&");
                pend.kind = used ? K_LAND : K_BAND;
            end
            M_PIPE: begin
                pend_v    = 1'b1;
                used      = (i_char == "|");
                pend.kind = used ? K_LOR : K_BOR;
            end
            default: begin
                n_mode = M_IDLE;
            end
        endcase

        if (pend_v || (r_mode == M_IDLE)) begin
            n_mode = M_IDLE;
            n_len  = 8'd0;
            n_cand = ALL_KW;
        end

        // byte not taken by a held token starts fresh
        if (!used) begin
            n_mode = M_IDLE;
            n_len  = 8'd0;
            n_cand = ALL_KW;
            unique case (i_char)
                CH_NUL: begin idl_v = 1'b1; idl.kind = K_EOF; end
                " ", CH_TAB, CH_CR: begin end
                CH_LF: begin idl_v = 1'b1; idl.kind = K_NEWLINE; end
                "(": begin idl_v = 1'b1; idl.kind = K_LPAREN; end
                ")": begin idl_v = 1'b1; idl.kind = K_RPAREN; end
                ",": begin idl_v = 1'b1; idl.kind = K_COMMA; end
                ":": begin idl_v = 1'b1; idl.kind = K_COLON; end
                "+": begin idl_v = 1'b1; idl.kind = K_PLUS; end
                "-": begin idl_v = 1'b1; idl.kind = K_MINUS; end
                "*": begin idl_v = 1'b1; idl.kind = K_TIMES; end
                "/": begin idl_v = 1'b1; idl.kind = K_DIVIDE; end
                "%": begin idl_v = 1'b1; idl.kind = K_MOD; end
                "~": begin idl_v = 1'b1; idl.kind = K_BNOT; end
                "^": begin idl_v = 1'b1; idl.kind = K_BXOR; end
                "\\": begin n_mode = M_BSLASH; n_start = r_pos; end
                "=": begin n_mode = M_EQ; n_start = r_pos; end
                "!": begin n_mode = M_BANG; n_start = r_pos; end
                "<": begin n_mode = M_LT; n_start = r_pos; end
                ">": begin n_mode = M_GT; n_start = r_pos; end
                "&": begin n_mode = M_AMP; n_start = r_pos; end
                "|": begin n_mode = M_PIPE; n_start = r_pos; end
                "#": begin
                    n_mode  = M_HASH;
                    n_start = r_pos;
                    n_cand  = kw_filter(ALL_KW, 8'd0, i_char);
                    n_len   = len_bump(8'd0);
                end
                default: begin
                    if (is_letter || (i_char == "_")) begin
                        n_mode  = M_IDENT;
                        n_start = r_pos;
                        n_cand  = kw_filter(ALL_KW, 8'd0, i_char);
                        n_len   = len_bump(8'd0);
                    end else if (is_digit) begin
                        n_mode  = M_NUMBER;
                        n_start = r_pos;
                        n_cand  = kw_filter(ALL_KW, 8'd0, i_char);
                        n_len   = len_bump(8'd0);
                    end else begin
                        idl_v    = 1'b1;
                        idl.kind = K_ERR;
                    end
                end
            endcase
        end
    end

    assign o_push     = i_acc && (pend_v || idl_v);
    assign o_rec.two  = pend_v && idl_v;
    assign o_rec.tok0 = pend_v ? pend : idl;
    assign o_rec.tok1 = idl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_cand  <= ALL_KW;
            r_len   <= 8'd0;
            r_start <= 32'd0;
            r_pos   <= 32'd0;
        end else if (i_acc) begin
            r_mode  <= n_mode;
            r_cand  <= n_cand;
            r_len   <= n_len;
            r_start <= n_start;
            r_pos   <= r_pos + 32'd1;
        end
    end

endmodule

// ----- sv/ptl_queue.sv -----
`timescale 1ns / 1ps

module ptl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ptl_pkg::t_rec i_rec,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output ptl_pkg::t_rec o_head
);
    import ptl_pkg::*;

    t_rec                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- sv/ptl_back.sv -----
`timescale 1ns / 1ps

module ptl_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  ptl_pkg::t_rec                  i_head,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic [ptl_pkg::DATA_OUT_W-1:0] o_m_tdata,
    output logic [ptl_pkg::USER_W-1:0]     o_m_tuser,
    output logic                           o_m_tlast,
    output logic                           o_pop
);
    import ptl_pkg::*;

    logic r_sel;
    t_tok tok;
    logic xfer;

    assign tok        = r_sel ? i_head.tok1 : i_head.tok0;
    assign o_m_tvalid = !i_empty;
    assign o_m_tlast  = i_head.two ? r_sel : 1'b1;
    assign o_m_tdata  = {tok.len, tok.start};
    assign o_m_tuser  = tok.kind;
    assign xfer       = o_m_tvalid && i_m_tready;
    assign o_pop      = xfer && o_m_tlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else if (xfer) begin
            r_sel <= !o_m_tlast;
        end
    end

endmodule

// ----- sv/preprocessor_token_lexer.sv -----
`timescale 1ns / 1ps
// preprocessor token lexer
// slave stream: one source byte per transfer in s_tdata[7:0]; byte 0 ends the text
// master stream: one token per transfer, m_tuser = kind[5:0], m_tdata = start[31:0],
//   length[39:32]; m_tlast marks the last token of one byte
// a byte that closes a held token and makes one of its own gives two tokens
// the lexer state machine takes one byte per cycle whenever the token queue
// (four entries, one entry per byte) has room; the queue head drives the
// master side directly, so a token can leave in the cycle after its byte
// throughput is one byte per cycle, bounded by the master side at one token
// per cycle: a byte that yields two tokens holds its queue entry until both leave
// bytes that give no token (blanks, the inner bytes of a name) never enter
// the queue
// when the receiver stalls the queue fills and s_tready drops; the lexer
// state holds until the next transfer
// synchronous reset clears the lexer state, the byte position and the queue
module preprocessor_token_lexer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [ptl_pkg::DATA_IN_W-1:0]  i_s_tdata,   // char_code
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [ptl_pkg::DATA_OUT_W-1:0] o_m_tdata,   // token_start, token_length
    output logic [ptl_pkg::USER_W-1:0]     o_m_tuser,   // token_kind
    output logic                           o_m_tlast    // last_of_run
);
    import ptl_pkg::*;

    logic w_acc, w_push, w_pop, w_full, w_empty;
    t_rec w_rec, w_head;

    assign o_s_tready = !w_full;
    assign w_acc      = i_s_tvalid && o_s_tready;

    ptl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_char  (i_s_tdata),
        .o_push  (w_push),
        .o_rec   (w_rec)
    );

    ptl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    ptl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_head     (w_head),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .o_pop      (w_pop)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("token queue written while full");

    a_eof_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_s_tdata == CH_NUL)) |-> w_push)
        else $error("end of text gave no token");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> o_m_tvalid)
        else $error("second token of a byte missing");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import ptl_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] start;
        logic [7:0]  len;
        logic        last;
    } t_exp_tok;

    typedef struct {
        logic [7:0]  ch;
        bit          typed;
        t_kind       kind;
        logic [31:0] start;
        logic [7:0]  len;
    } t_row;

    localparam int N_ROWS = 25;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [DATA_IN_W-1:0]  i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [DATA_OUT_W-1:0] o_m_tdata;
    logic [USER_W-1:0]     o_m_tuser;
    logic                  o_m_tlast;

    preprocessor_token_lexer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #6 i_clk = ~i_clk;

    string kw_word [NKW] = '{
        "#define", "#undef", "#ifdef", "#ifndef", "#if", "#elif", "#else",
        "#endif", "#error", "#pragma", "#extension", "#version", "#line",
        "#include", "defined"
    };
    string op_word [22] = '{
        "(", ")", ",", ":", "+", "-", "*", "/", "%", "==", "!=", "<", "<=",
        ">", ">=", "&", "|", "~", "^", "&&", "||", "!"
    };

    // lexer copy kept by the bench
    t_mode          lx_mode;
    logic [NKW-1:0] kw_live;
    logic [7:0]     run_len;
    logic [31:0]    run_start;
    logic [31:0]    char_pos;

    t_exp_tok   byte_tokens [$];
    t_exp_tok   due_tokens [$];
    logic [7:0] src_text [$];
    int         src_idle;
    int         sink_stall;
    int         n_bad;

    t_row script [N_ROWS] = '{
        '{"(",    1, K_LPAREN, 32'd0,  8'd0},
        '{")",    1, K_RPAREN, 32'd1,  8'd0},
        '{8'hFF,  1, K_ERR,    32'd2,  8'd0},
        '{CH_NUL, 1, K_EOF,    32'd3,  8'd0},
        '{"=",    0, K_ERR,    32'd0,  8'd0},
        '{"x",    1, K_ERR,    32'd4,  8'd0},
        '{"\\",   0, K_ERR,    32'd0,  8'd0},
        '{CH_CR,  0, K_ERR,    32'd0,  8'd0},
        '{CH_LF,  0, K_ERR,    32'd0,  8'd0},
        '{"#",    0, K_ERR,    32'd0,  8'd0},
        '{" ",    0, K_ERR,    32'd0,  8'd0},
        '{"1",    1, K_ERR,    32'd9,  8'd1},
        '{"\\",   0, K_ERR,    32'd0,  8'd0},
        '{"a",    1, K_ERR,    32'd12, 8'd0},
        '{"#",    0, K_ERR,    32'd0,  8'd0},
        '{CH_TAB, 0, K_ERR,    32'd0,  8'd0},
        '{"i",    0, K_ERR,    32'd0,  8'd0},
        '{"f",    0, K_ERR,    32'd0,  8'd0},
        '{"(",    0, K_ERR,    32'd0,  8'd0},
        '{"!",    0, K_ERR,    32'd0,  8'd0},
        '{"=",    0, K_ERR,    32'd0,  8'd0},
        '{"9",    0, K_ERR,    32'd0,  8'd0},
        '{"9",    0, K_ERR,    32'd0,  8'd0},
        '{CH_NUL, 0, K_ERR,    32'd0,  8'd0},
        '{8'h80,  1, K_ERR,    32'd24, 8'd0}
    };

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void add_src(logic [7:0] c);
        src_text = {src_text, c};
    endfunction

    function automatic void add_due(t_exp_tok t);
        due_tokens = {due_tokens, t};
    endfunction

    function automatic void put_tok(t_kind k, logic [31:0] s, logic [7:0] l);
        t_exp_tok t;
        t = '{k, s, l, 1'b0};
        byte_tokens = {byte_tokens, t};
    endfunction

    function automatic void rest();
        lx_mode = M_IDLE;
        run_len = '0;
        kw_live = '1;
    endfunction

    function automatic void open_run(t_mode m, logic [31:0] p);
        lx_mode   = m;
        run_start = p;
        run_len   = '0;
        kw_live   = '1;
    endfunction

    function automatic void keep_char(logic [7:0] c);
        for (int k = 0; k < NKW; k++) begin
            if (run_len >= kw_word[k].len() || kw_word[k][int'(run_len)] != c) begin
                kw_live[k] = 1'b0;
            end
        end
        if (run_len < 8'd255) begin
            run_len = run_len + 8'd1;
        end
    endfunction

    function automatic void close_word();
        t_kind k_out;
        k_out = K_IDENT;
        for (int k = 0; k < NKW; k++) begin
            if (kw_live[k] && kw_word[k].len() == run_len) begin
                k_out = t_kind'(6'(int'(K_DEFINE) + k));
            end
        end
        put_tok(k_out, run_start, run_len);
        rest();
    endfunction

    // held operator: second byte either completes it or is handed back
    function automatic bit end_pair(logic [7:0] c, logic [7:0] second,
                                    t_kind two_kind, t_kind one_kind);
        if (c == second) begin
            put_tok(two_kind, run_start, '0);
            rest();
            return 1'b1;
        end
        put_tok(one_kind, run_start, '0);
        rest();
        return 1'b0;
    endfunction

    function automatic void lex_char(logic [7:0] c);
        bit used;
        used = 1'b0;
        byte_tokens.delete();
        case (lx_mode)
            M_IDLE: ;
            M_IDENT: begin
                if (is_letter(c) || is_digit(c) || c == "_") begin
                    keep_char(c);
                    used = 1'b1;
                end else begin
                    close_word();
                end
            end
            M_NUMBER: begin
                if (is_digit(c)) begin
                    keep_char(c);
                    used = 1'b1;
                end else begin
                    put_tok(K_INT, run_start, run_len);
                    rest();
                end
            end
            M_HASH: begin
                if (c == " " || c == CH_TAB) begin
                    used = 1'b1;
                end else if (is_letter(c)) begin
                    lx_mode = M_IDENT;
                    keep_char(c);
                    used = 1'b1;
                end else begin
                    put_tok(K_ERR, run_start, run_len);
                    rest();
                end
            end
            M_BSLASH: begin
                if (c == CH_CR) begin
                    lx_mode = M_BSLASH_CR;
                    used = 1'b1;
                end else begin
                    used = end_pair(c, CH_LF, K_LINEWRAP, K_ERR);
                end
            end
            M_BSLASH_CR: used = end_pair(c, CH_LF, K_LINEWRAP, K_ERR);
            M_EQ:        used = end_pair(c, "=", K_EQ, K_ERR);
            M_BANG:      used = end_pair(c, "=", K_NE, K_LNOT);
            M_LT:        used = end_pair(c, "=", K_LE, K_LT);
            M_GT:        used = end_pair(c, "=", K_GE, K_GT);
            M_AMP:       used = end_pair(c, "&", K_LAND, K_BAND);
            M_PIPE:      used = end_pair(c, "|", K_LOR, K_BOR);
            default:     rest();
        endcase
        if (!used) begin
            case (c)
                CH_NUL:            put_tok(K_EOF, char_pos, '0);
                " ", CH_TAB, CH_CR: ;
                CH_LF:             put_tok(K_NEWLINE, char_pos, '0);
                "(":               put_tok(K_LPAREN, char_pos, '0);
                ")":               put_tok(K_RPAREN, char_pos, '0);
                ",":               put_tok(K_COMMA, char_pos, '0);
                ":":               put_tok(K_COLON, char_pos, '0);
                "+":               put_tok(K_PLUS, char_pos, '0);
                "-":               put_tok(K_MINUS, char_pos, '0);
                "*":               put_tok(K_TIMES, char_pos, '0);
                "/":               put_tok(K_DIVIDE, char_pos, '0);
                "%":               put_tok(K_MOD, char_pos, '0);
                "~":               put_tok(K_BNOT, char_pos, '0);
                "^":               put_tok(K_BXOR, char_pos, '0);
                "\\":              open_run(M_BSLASH, char_pos);
                "=":               open_run(M_EQ, char_pos);
                "!":               open_run(M_BANG, char_pos);
                "<":               open_run(M_LT, char_pos);
                ">":               open_run(M_GT, char_pos);
                "&":               open_run(M_AMP, char_pos);
                "|":               open_run(M_PIPE, char_pos);
                "#": begin
                    open_run(M_HASH, char_pos);
                    keep_char(c);
                end
                default: begin
                    if (is_letter(c) || c == "_") begin
                        open_run(M_IDENT, char_pos);
                        keep_char(c);
                    end else if (is_digit(c)) begin
                        open_run(M_NUMBER, char_pos);
                        keep_char(c);
                    end else begin
                        put_tok(K_ERR, char_pos, '0);
                    end
                end
            endcase
        end
        char_pos = char_pos + 32'd1;
        if (byte_tokens.size() > 0) begin
            byte_tokens[byte_tokens.size()-1].last = 1'b1;
        end
    endfunction

    function automatic logic [7:0] name_char(bit lead);
        int r;
        r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r == 52) return "_";
        return 8'("0" + r - 53);
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) begin
            add_src(s[i]);
        end
    endfunction

    function automatic void add_run(bit digits, int n);
        for (int i = 0; i < n; i++) begin
            add_src(digits ? 8'("0" + $urandom_range(0, 9)) : name_char(i == 0));
        end
        if ($urandom_range(0, 1)) begin
            add_src(" ");
        end
    endfunction

    // one piece of source text: mostly well-formed, some broken, some noise
    function automatic void add_chunk();
        int    r;
        string w;
        r = $urandom_range(0, 999);
        if (r < 4) begin
            add_run($urandom_range(0, 1), $urandom_range(256, 290));
        end else if (r < 200) begin
            w = kw_word[$urandom_range(0, NKW-1)];
            if (w[0] == "#") begin
                add_src("#");
                repeat ($urandom_range(0, 2)) begin
                    add_src($urandom_range(0, 1) ? " " : CH_TAB);
                end
                add_str(w.substr(1, w.len()-1));
            end else begin
                add_str(w);
            end
            if ($urandom_range(0, 5) == 0) begin
                add_src(name_char(1'b0));
            end
            if ($urandom_range(0, 1)) begin
                add_src(" ");
            end
        end else if (r < 350) begin
            add_run(1'b0, $urandom_range(1, 8));
        end else if (r < 450) begin
            add_run(1'b1, $urandom_range(1, 6));
        end else if (r < 650) begin
            add_str(op_word[$urandom_range(0, 21)]);
        end else if (r < 720) begin
            case ($urandom_range(0, 2))
                0:       add_src(" ");
                1:       add_src(CH_TAB);
                default: add_src(CH_CR);
            endcase
        end else if (r < 780) begin
            add_src(CH_LF);
        end else if (r < 830) begin
            add_src("\\");
            if ($urandom_range(0, 1)) begin
                add_src(CH_CR);
            end
            add_src(CH_LF);
        end else if (r < 880) begin
            case ($urandom_range(0, 3))
                0: add_src("\\");
                1: begin
                    add_src("\\");
                    add_src(CH_CR);
                end
                2: add_src("=");
                default: begin
                    add_src("#");
                    if ($urandom_range(0, 1)) begin
                        add_src(" ");
                    end
                    add_src(8'("0" + $urandom_range(0, 9)));
                end
            endcase
            add_src(8'($urandom_range(0, 255)));
        end else if (r < 970) begin
            add_src(8'($urandom_range(0, 255)));
        end else begin
            add_src(CH_NUL);
        end
    endfunction

    task automatic send_byte(input logic [7:0] c, input bit typed, input t_exp_tok fixed);
        while ($urandom_range(99) < src_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        lex_char(c);
        if (typed) begin
            add_due(fixed);
        end else begin
            foreach (byte_tokens[i]) begin
                add_due(byte_tokens[i]);
            end
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_bytes,
                             input bit with_long);
        int sent;
        sent       = 0;
        src_idle   = idle_pct;
        sink_stall = stall_pct;
        src_text.delete();
        if (with_long) begin
            add_run(1'b0, 270);
        end
        while (sent < n_bytes) begin
            if (src_text.size() == 0) begin
                add_chunk();
            end
            send_byte(src_text.pop_front(), 1'b0, '0);
            sent++;
        end
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (due_tokens.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // token side: compare each transfer with the oldest expected token
    always @(posedge i_clk) begin : token_sink
        t_exp_tok got;
        t_exp_tok want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{t_kind'(o_m_tuser), o_m_tdata[31:0], o_m_tdata[39:32], o_m_tlast};
            if (due_tokens.size() == 0) begin
                $display("%0t: unexpected token kind %0d start %0d len %0d last %0d",
                         $time, got.kind, got.start, got.len, got.last);
                n_bad++;
            end else begin
                want = due_tokens.pop_front();
                if (got.kind != want.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                    n_bad++;
                end
                if (got.start != want.start) begin
                    $display("%0t: start expected %0d actual %0d",
                             $time, want.start, got.start);
                    n_bad++;
                end
                if (got.len != want.len) begin
                    $display("%0t: length expected %0d actual %0d", $time, want.len, got.len);
                    n_bad++;
                end
                if (got.last != want.last) begin
                    $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                    n_bad++;
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= sink_stall);
    end

    initial begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        n_bad      = 0;
        src_idle   = 0;
        sink_stall = 0;
        rest();
        run_start  = '0;
        char_pos   = '0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_m_tready <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            send_byte(script[i].ch, script[i].typed,
                      '{script[i].kind, script[i].start, script[i].len, 1'b1});
        end

        run_phase(0, 0, 460, 1'b1);
        drain();
        run_phase(59, 0, 460, 1'b0);
        run_phase(0, 59, 460, 1'b0);
        drain();
        run_phase(14, 14, 460, 1'b0);
        drain();
        repeat (10) @(posedge i_clk);

        if (n_bad == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/ptl_pkg.sv
sv/ptl_front.sv
sv/ptl_queue.sv
sv/ptl_back.sv
sv/preprocessor_token_lexer.sv
bench/tb.sv
